[design/pewt_pkg.sv]
// Shared types and constants for the ECAM and window translator.
`default_nettype none
package pewt_pkg;

  localparam int CONTROLLERS_DEF = 16;
  localparam int RANGES_DEF      = 64;

  localparam logic [1:0] KIND_LOAD_CTRL = 2'd0;
  localparam logic [1:0] KIND_LOAD_WIN  = 2'd1;
  localparam logic [1:0] KIND_CONFIG    = 2'd2;
  localparam logic [1:0] KIND_TRANSLATE = 2'd3;

  localparam logic [1:0] SPACE_MEM32 = 2'd2;
  localparam logic [1:0] SPACE_MEM64 = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  index;
    logic [15:0] segment;
    logic [7:0]  bus;
    logic [7:0]  bus_last;
    logic [4:0]  slot;
    logic [2:0]  function_req;
    logic [11:0] offset;
    logic [63:0] base_address;
    logic [63:0] pci_address;
    logic [63:0] window_size;
    logic [1:0]  win_space;
  } req_t;

  typedef struct packed {
    logic [63:0] address;
    logic        found;
  } rsp_t;

  typedef struct packed {
    logic [15:0] segment;
    logic [7:0]  bus_first;
    logic [7:0]  bus_last;
    logic [63:0] base;
  } ctrl_entry_t;

  typedef struct packed {
    logic [63:0] pci_base;
    logic [63:0] cpu_base;
    logic [63:0] size;
    logic [1:0]  space;
  } win_entry_t;

  typedef struct packed {
    logic load;
    logic win;
  } unit_ctl_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] sum;
  } unit_res_t;

endpackage
`default_nettype wire

[design/pewt_table.sv]
// Entry table: one write port, one registered read port, per-entry valid flags.
`default_nettype none
module pewt_table #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic                                        rvalid,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata  <= mem[raddr];
    rvalid <= vld[raddr];
  end

endmodule
`default_nettype wire

[design/pewt_match_unit.sv]
// Shared match and address unit: subtract and test, then compare and add.
`default_nettype none
module pewt_match_unit (
  input  wire logic                 clk,
  input  wire pewt_pkg::unit_ctl_t  ctl,
  input  wire pewt_pkg::req_t       job,
  input  wire logic                 c_valid,
  input  wire pewt_pkg::ctrl_entry_t c_entry,
  input  wire logic                 w_valid,
  input  wire pewt_pkg::win_entry_t w_entry,
  output pewt_pkg::unit_res_t       res
);

  logic [63:0] op_a;
  logic [63:0] op_b;
  logic [64:0] diff;
  logic        ok;
  logic        mem_space;

  logic        s_ok;
  logic        s_win;
  logic [63:0] s_delta;
  logic [63:0] s_base;
  logic [63:0] s_size;
  logic [63:0] addend;

  assign op_a = ctl.win ? job.pci_address : 64'(job.bus);
  assign op_b = ctl.win ? w_entry.pci_base : 64'(c_entry.bus_first);
  assign diff = {1'b0, op_a} - {1'b0, op_b};

  assign mem_space = (w_entry.space == pewt_pkg::SPACE_MEM32) ||
                     (w_entry.space == pewt_pkg::SPACE_MEM64);

  always_comb begin
    if (ctl.win) begin
      ok = w_valid && mem_space && !diff[64];
    end else begin
      ok = c_valid && (c_entry.segment == job.segment) && !diff[64] &&
           (job.bus <= c_entry.bus_last);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      s_ok    <= ok;
      s_win   <= ctl.win;
      s_delta <= diff[63:0];
      s_base  <= ctl.win ? w_entry.cpu_base : c_entry.base;
      s_size  <= w_entry.size;
    end
  end

  assign addend  = s_win ? s_delta
                         : {36'd0, s_delta[7:0], job.slot, job.function_req, job.offset};
  assign res.hit = s_ok && (!s_win || (s_delta < s_size));
  assign res.sum = s_base + addend;

endmodule
`default_nettype wire

[design/pewt_seq.sv]
// Sequencer: handshakes, table writes, entry scan and result capture.
`default_nettype none
module pewt_seq #(
  parameter int CONTROLLERS = pewt_pkg::CONTROLLERS_DEF,
  parameter int RANGES      = pewt_pkg::RANGES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_ready,
  input  wire pewt_pkg::req_t        req,
  output logic                       rsp_valid,
  input  wire logic                  rsp_ready,
  output pewt_pkg::rsp_t             rsp,
  output logic                       c_we,
  output logic [(CONTROLLERS > 1 ? $clog2(CONTROLLERS) : 1)-1:0] c_waddr,
  output pewt_pkg::ctrl_entry_t      c_wdata,
  output logic [(CONTROLLERS > 1 ? $clog2(CONTROLLERS) : 1)-1:0] c_raddr,
  output logic                       w_we,
  output logic [(RANGES > 1 ? $clog2(RANGES) : 1)-1:0] w_waddr,
  output pewt_pkg::win_entry_t       w_wdata,
  output logic [(RANGES > 1 ? $clog2(RANGES) : 1)-1:0] w_raddr,
  output pewt_pkg::unit_ctl_t        ctl,
  output pewt_pkg::req_t             job,
  input  wire pewt_pkg::unit_res_t   res
);

  localparam int CAW  = CONTROLLERS > 1 ? $clog2(CONTROLLERS) : 1;
  localparam int RAW  = RANGES > 1 ? $clog2(RANGES) : 1;
  localparam int MAXN = RANGES > CONTROLLERS ? RANGES : CONTROLLERS;
  localparam int SW   = $clog2(MAXN + 1);
  localparam logic [SW-1:0] C_LIM = SW'(CONTROLLERS);
  localparam logic [SW-1:0] R_LIM = SW'(RANGES);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]    state;
  logic [SW-1:0] cnt;
  logic          win;
  logic          v1;
  logic          v2;
  logic          issue;
  logic          accept;
  logic          c_ok;
  logic          w_ok;
  logic [8:0]    idx_ext;
  logic [63:0]   res_addr;
  logic          res_found;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign issue     = (state == ST_SCAN) && (cnt < (win ? R_LIM : C_LIM));

  assign idx_ext = 9'(req.index);
  assign c_ok    = 32'(req.index) < CONTROLLERS;
  assign w_ok    = 32'(req.index) < RANGES;

  assign c_we    = accept && (req.kind == pewt_pkg::KIND_LOAD_CTRL) && c_ok;
  assign c_waddr = idx_ext[CAW-1:0];
  assign c_wdata = '{segment: req.segment, bus_first: req.bus, bus_last: req.bus_last,
                     base: req.base_address};
  assign w_we    = accept && (req.kind == pewt_pkg::KIND_LOAD_WIN) && w_ok;
  assign w_waddr = idx_ext[RAW-1:0];
  assign w_wdata = '{pci_base: req.pci_address, cpu_base: req.base_address,
                     size: req.window_size, space: req.win_space};

  assign c_raddr  = cnt[CAW-1:0];
  assign w_raddr  = cnt[RAW-1:0];
  assign ctl.load = v1;
  assign ctl.win  = win;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      if ((state == ST_FINISH) && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if ((req.kind == pewt_pkg::KIND_LOAD_CTRL) ||
                (req.kind == pewt_pkg::KIND_LOAD_WIN)) begin
              state <= ST_FINISH;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (!issue && !v1 && !v2) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= req;
      win <= (req.kind == pewt_pkg::KIND_TRANSLATE);
      cnt <= '0;
      case (req.kind)
        pewt_pkg::KIND_LOAD_CTRL: begin
          res_found <= c_ok;
          res_addr  <= '0;
        end
        pewt_pkg::KIND_LOAD_WIN: begin
          res_found <= w_ok;
          res_addr  <= '0;
        end
        pewt_pkg::KIND_TRANSLATE: begin
          res_found <= 1'b0;
          res_addr  <= req.pci_address;
        end
        default: begin
          res_found <= 1'b0;
          res_addr  <= '0;
        end
      endcase
    end else if (state == ST_SCAN) begin
      if (issue) begin
        cnt <= cnt + SW'(1);
      end
      if (v2 && res.hit && !res_found) begin
        res_found <= 1'b1;
        res_addr  <= res.sum;
      end
    end
    if ((state == ST_FINISH) && (!rsp_valid || rsp_ready)) begin
      rsp.address <= res_addr;
      rsp.found   <= res_found;
    end
  end

endmodule
`default_nettype wire

[design/pcie_ecam_and_window_translator.sv]
// Top level of the PCIe ECAM address decoder and window translator.
//
//  channel | ports                  | dir | word
//  --------+------------------------+-----+---------------------------
//  request | req_valid/req_ready    | in  | pewt_pkg::req_t on req
//  result  | rsp_valid/rsp_ready    | out | pewt_pkg::rsp_t on rsp
//
// A load passes from the idle state to the finish state, then its result is registered.
// Config lookups and window translates scan one table entry per cycle through
// the shared match unit.
// rst clears all valid flags; table contents are not cleared.
// A new word is accepted once the previous result is in the output register;
// a stalled result holds the sequencer in its finish state.
`default_nettype none
module pcie_ecam_and_window_translator #(
  parameter int CONTROLLERS = pewt_pkg::CONTROLLERS_DEF,
  parameter int RANGES      = pewt_pkg::RANGES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire pewt_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output pewt_pkg::rsp_t      rsp
);

  localparam int CAW = CONTROLLERS > 1 ? $clog2(CONTROLLERS) : 1;
  localparam int RAW = RANGES > 1 ? $clog2(RANGES) : 1;

  logic                  c_we;
  logic [CAW-1:0]        c_waddr;
  logic [CAW-1:0]        c_raddr;
  pewt_pkg::ctrl_entry_t c_wdata;
  pewt_pkg::ctrl_entry_t c_rdata;
  logic                  c_rvalid;
  logic                  w_we;
  logic [RAW-1:0]        w_waddr;
  logic [RAW-1:0]        w_raddr;
  pewt_pkg::win_entry_t  w_wdata;
  pewt_pkg::win_entry_t  w_rdata;
  logic                  w_rvalid;
  pewt_pkg::unit_ctl_t   ctl;
  pewt_pkg::unit_res_t   res;
  pewt_pkg::req_t        job;

  pewt_seq #(
    .CONTROLLERS(CONTROLLERS),
    .RANGES     (RANGES)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .c_we     (c_we),
    .c_waddr  (c_waddr),
    .c_wdata  (c_wdata),
    .c_raddr  (c_raddr),
    .w_we     (w_we),
    .w_waddr  (w_waddr),
    .w_wdata  (w_wdata),
    .w_raddr  (w_raddr),
    .ctl      (ctl),
    .job      (job),
    .res      (res)
  );

  pewt_table #(
    .DEPTH(CONTROLLERS),
    .WIDTH($bits(pewt_pkg::ctrl_entry_t))
  ) u_ctrl_table (
    .clk   (clk),
    .rst   (rst),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rvalid(c_rvalid),
    .rdata (c_rdata)
  );

  pewt_table #(
    .DEPTH(RANGES),
    .WIDTH($bits(pewt_pkg::win_entry_t))
  ) u_win_table (
    .clk   (clk),
    .rst   (rst),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rvalid(w_rvalid),
    .rdata (w_rdata)
  );

  pewt_match_unit u_match (
    .clk    (clk),
    .ctl    (ctl),
    .job    (job),
    .c_valid(c_rvalid),
    .c_entry(c_rdata),
    .w_valid(w_rvalid),
    .w_entry(w_rdata),
    .res    (res)
  );

endmodule
`default_nettype wire

[tb/sv/pewt_result_checker.sv]
`timescale 1ns / 1ps
// Checker for the translator: predicts every result from the request stream and compares.
module pewt_result_checker
  import pewt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   mismatches,
  output int   outstanding
);

  localparam int CTRL_N = CONTROLLERS_DEF;
  localparam int WIN_N  = RANGES_DEF;

  ctrl_entry_t ctrl_tab  [CTRL_N];
  logic        ctrl_live [CTRL_N];
  win_entry_t  win_tab   [WIN_N];
  logic        win_live  [WIN_N];
  rsp_t        expected_rsp [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    foreach (ctrl_live[i]) ctrl_live[i] = 1'b0;
    foreach (win_live[i]) win_live[i] = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic rsp_t decode_word(input req_t w);
    rsp_t        r;
    logic [63:0] delta;
    logic        hit;
    r   = '0;
    hit = 1'b0;
    case (w.kind)
      KIND_LOAD_CTRL: begin
        if (w.index < CTRL_N) begin
          ctrl_tab[w.index]  = '{segment: w.segment, bus_first: w.bus,
                                 bus_last: w.bus_last, base: w.base_address};
          ctrl_live[w.index] = 1'b1;
          r.found            = 1'b1;
        end
      end
      KIND_LOAD_WIN: begin
        if (w.index < WIN_N) begin
          win_tab[w.index]  = '{pci_base: w.pci_address, cpu_base: w.base_address,
                                size: w.window_size, space: w.win_space};
          win_live[w.index] = 1'b1;
          r.found           = 1'b1;
        end
      end
      KIND_CONFIG: begin
        for (int i = 0; i < CTRL_N; i++) begin
          if (!hit && ctrl_live[i] && ctrl_tab[i].segment == w.segment &&
              w.bus >= ctrl_tab[i].bus_first && w.bus <= ctrl_tab[i].bus_last) begin
            hit       = 1'b1;
            r.address = ctrl_tab[i].base
                      + (64'(w.bus - ctrl_tab[i].bus_first) << 20)
                      + (64'(w.slot) << 15) + (64'(w.function_req) << 12)
                      + 64'(w.offset);
          end
        end
        r.found = hit;
      end
      KIND_TRANSLATE: begin
        r.address = w.pci_address;
        for (int i = 0; i < WIN_N; i++) begin
          delta = w.pci_address - win_tab[i].pci_base;
          if (!hit && win_live[i] &&
              (win_tab[i].space == SPACE_MEM32 || win_tab[i].space == SPACE_MEM64) &&
              w.pci_address >= win_tab[i].pci_base && delta < win_tab[i].size) begin
            hit       = 1'b1;
            r.address = win_tab[i].cpu_base + delta;
          end
        end
        r.found = hit;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("unexpected result", rsp.address, '0);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.address !== want.address) begin
            report_mismatch("address", rsp.address, want.address);
          end
          if (rsp.found !== want.found) begin
            report_mismatch("found", 64'(rsp.found), 64'(want.found));
          end
        end
      end
      if (req_valid && req_ready) begin
        expected_rsp.push_back(decode_word(req));
      end
      outstanding = expected_rsp.size();
    end
  end

endmodule

[tb/sv/tb_pcie_ecam_and_window_translator.sv]
`timescale 1ns / 1ps
// Testbench top for the translator: request stimulus, result back-pressure and verdict.
module tb_pcie_ecam_and_window_translator;
  import pewt_pkg::*;

  localparam int RANDOM_WORDS = 2000;
  localparam int CALM_WORDS   = 150;
  localparam int DRAIN_LIMIT  = 4000;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_CYCLES  = 300;

  localparam logic [1:0] SPACE_CFG = 2'd0;
  localparam logic [1:0] SPACE_IO  = 2'd1;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  int   mismatches;
  int   outstanding;
  bit   calm      = 1'b0;

  logic [15:0] seg_of   [CONTROLLERS_DEF];
  logic [7:0]  first_of [CONTROLLERS_DEF];
  logic [7:0]  last_of  [CONTROLLERS_DEF];
  bit          ctrl_set [CONTROLLERS_DEF];
  logic [63:0] win_base [RANGES_DEF];
  logic [63:0] win_len  [RANGES_DEF];
  bit          win_mem  [RANGES_DEF];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pcie_ecam_and_window_translator u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  pewt_result_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t noise_word();
    logic [255:0] raw;
    raw = {rand64(), rand64(), rand64(), rand64()};
    return raw[$bits(req_t)-1:0];
  endfunction

  function automatic req_t ctrl_word(input logic [5:0] idx, input logic [15:0] seg,
                                     input logic [7:0] first, input logic [7:0] last,
                                     input logic [63:0] base);
    req_t w;
    w              = noise_word();
    w.kind         = KIND_LOAD_CTRL;
    w.index        = idx;
    w.segment      = seg;
    w.bus          = first;
    w.bus_last     = last;
    w.base_address = base;
    return w;
  endfunction

  function automatic req_t win_word(input logic [5:0] idx, input logic [1:0] space,
                                    input logic [63:0] pci, input logic [63:0] len,
                                    input logic [63:0] cpu);
    req_t w;
    w              = noise_word();
    w.kind         = KIND_LOAD_WIN;
    w.index        = idx;
    w.win_space    = space;
    w.pci_address  = pci;
    w.window_size  = len;
    w.base_address = cpu;
    return w;
  endfunction

  function automatic req_t cfg_word(input logic [15:0] seg, input logic [7:0] bus,
                                    input logic [4:0] slot, input logic [2:0] fn,
                                    input logic [11:0] off);
    req_t w;
    w              = noise_word();
    w.kind         = KIND_CONFIG;
    w.segment      = seg;
    w.bus          = bus;
    w.slot         = slot;
    w.function_req = fn;
    w.offset       = off;
    return w;
  endfunction

  function automatic req_t xlate_word(input logic [63:0] pci);
    req_t w;
    w             = noise_word();
    w.kind        = KIND_TRANSLATE;
    w.pci_address = pci;
    return w;
  endfunction

  function automatic logic [15:0] pick_segment();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'h0001;
      2:       return 16'hFFFF;
      3:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic req_t random_word();
    int          pick;
    int          id;
    bit          aimed;
    logic [7:0]  first;
    logic [63:0] off;
    logic [63:0] len;
    logic [63:0] base;
    pick  = $urandom_range(0, 99);
    aimed = 1'b0;
    id    = 0;
    if (pick < 10) begin
      first = 8'($urandom);
      base  = ($urandom_range(0, 4) == 0) ? (64'hFFFF_FFFF_F000_0000 | 64'($urandom))
                                           : rand64();
      return ctrl_word(($urandom_range(0, 9) == 0) ? 6'($urandom_range(16, 63))
                                                   : 6'($urandom_range(0, 15)),
                       pick_segment(), first,
                       ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                   : first + 8'($urandom_range(0, 15)),
                       base);
    end
    if (pick < 25) begin
      case ($urandom_range(0, 7))
        0:       len = 64'd0;
        1:       len = rand64();
        2, 3:    len = {32'd0, $urandom};
        default: len = 64'($urandom_range(1, 'h10000));
      endcase
      base = ($urandom_range(0, 3) == 0) ? (64'hFFFF_FFFF_FFFF_0000 | 64'($urandom))
                                          : rand64();
      return win_word(6'($urandom_range(0, 63)),
                      ($urandom_range(0, 4) == 0) ? 2'($urandom)
                                                  : ($urandom_range(0, 1) ? SPACE_MEM32
                                                                          : SPACE_MEM64),
                      base, len, rand64());
    end
    if (pick < 60) begin
      for (int t = 0; t < 8 && !aimed; t++) begin
        id = $urandom_range(0, CONTROLLERS_DEF - 1);
        if (ctrl_set[id] && last_of[id] >= first_of[id]) aimed = 1'b1;
      end
      if (aimed && $urandom_range(0, 4) != 0) begin
        return cfg_word(seg_of[id],
                        first_of[id] + 8'($urandom_range(0, last_of[id] - first_of[id])),
                        5'($urandom), 3'($urandom), 12'($urandom));
      end
      return cfg_word(pick_segment(), 8'($urandom), 5'($urandom), 3'($urandom),
                      12'($urandom));
    end
    for (int t = 0; t < 8 && !aimed; t++) begin
      id = $urandom_range(0, RANGES_DEF - 1);
      if (win_mem[id]) aimed = 1'b1;
    end
    if (aimed && $urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 5))
        0:       off = win_len[id] - 64'd1;
        1:       off = win_len[id];
        2:       off = '1;
        default: off = (win_len[id] == 0) ? 64'd0 : rand64() % win_len[id];
      endcase
      return xlate_word(win_base[id] + off);
    end
    return xlate_word(rand64());
  endfunction

  task automatic send_word(input req_t w);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (w.kind == KIND_LOAD_CTRL && w.index < CONTROLLERS_DEF) begin
      seg_of[w.index]   = w.segment;
      first_of[w.index] = w.bus;
      last_of[w.index]  = w.bus_last;
      ctrl_set[w.index] = 1'b1;
    end
    if (w.kind == KIND_LOAD_WIN && w.index < RANGES_DEF) begin
      win_base[w.index] = w.pci_address;
      win_len[w.index]  = w.window_size;
      win_mem[w.index]  = (w.win_space == SPACE_MEM32 || w.win_space == SPACE_MEM64);
    end
  endtask

  initial begin : result_side
    int hold;
    int taken;
    bit pressed;
    hold    = 0;
    taken   = 0;
    pressed = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (rsp_valid && rsp_ready) taken++;
        if (!pressed && taken == HOLD_AT) begin
          pressed = 1'b1;
          hold    = HOLD_CYCLES;
        end else if (hold == 0 && !calm && $urandom_range(0, 7) == 0) begin
          hold = $urandom_range(1, 14);
        end
        if (hold > 0) begin
          rsp_ready <= 1'b0;
          hold--;
        end else begin
          rsp_ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("[pcie_ecam_and_window_translator] ERROR");
    $finish;
  end

  initial begin : request_side
    int waited;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_word(cfg_word(16'h0000, 8'h00, 5'd0, 3'd0, 12'h000));
    send_word(xlate_word(64'h0000_0000_8000_0000));
    send_word(ctrl_word(6'd0, 16'h0000, 8'h00, 8'hFF, 64'h0));
    send_word(ctrl_word(6'd15, 16'hFFFF, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF));
    send_word(ctrl_word(6'd16, 16'h1234, 8'h00, 8'hFF, 64'hE000_0000));
    send_word(ctrl_word(6'd63, 16'h1234, 8'h00, 8'hFF, 64'hE000_0000));
    send_word(ctrl_word(6'd3, 16'h0005, 8'h0A, 8'h09, 64'hC000_0000));
    send_word(cfg_word(16'h0000, 8'h00, 5'd0, 3'd0, 12'h000));
    send_word(cfg_word(16'h0000, 8'hFF, 5'd31, 3'd7, 12'hFFF));
    send_word(cfg_word(16'hFFFF, 8'hFF, 5'd31, 3'd7, 12'hFFF));
    send_word(cfg_word(16'h0005, 8'h0A, 5'd1, 3'd1, 12'h010));
    send_word(cfg_word(16'h1234, 8'h00, 5'd2, 3'd0, 12'h004));
    send_word(ctrl_word(6'd1, 16'h0000, 8'h10, 8'h1F, 64'hF000_0000));
    send_word(ctrl_word(6'd0, 16'h0000, 8'h20, 8'h2F, 64'hD000_0000));
    send_word(cfg_word(16'h0000, 8'h10, 5'd3, 3'd2, 12'h100));
    send_word(cfg_word(16'h0000, 8'h00, 5'd0, 3'd0, 12'h000));
    send_word(win_word(6'd0, SPACE_IO, 64'h1000, 64'h1000, 64'hF000_0000));
    send_word(win_word(6'd1, SPACE_MEM32, 64'h1000, 64'h1000, 64'hF000_0000));
    send_word(win_word(6'd2, SPACE_MEM64, 64'h4000, 64'h0, 64'hA000_0000));
    send_word(win_word(6'd3, SPACE_CFG, 64'h4000, 64'h1000, 64'hB000_0000));
    send_word(win_word(6'd63, SPACE_MEM64, 64'hFFFF_FFFF_FFFF_F000, 64'h2000,
                       64'hFFFF_FFFF_FFFF_F800));
    send_word(xlate_word(64'h0FFF));
    send_word(xlate_word(64'h1000));
    send_word(xlate_word(64'h1FFF));
    send_word(xlate_word(64'h2000));
    send_word(xlate_word(64'h4000));
    send_word(xlate_word(64'hFFFF_FFFF_FFFF_FFFF));
    send_word(xlate_word(64'h0000_0000_0000_0800));

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      send_word(random_word());
    end
    req_valid <= 1'b0;

    @(posedge clk);
    waited = 0;
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (RANGES_DEF + 8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[pcie_ecam_and_window_translator] OK");
    end else begin
      $display("[pcie_ecam_and_window_translator] ERROR");
    end
    $finish;
  end

endmodule
